FILE: hdl/clcd_pkg.sv
// clcd_pkg: shared types and codes for the 4-bit character lcd controller
// no dependencies; imported by every module of the block

package clcd_pkg;

    // command kinds
    typedef logic [2:0] clcd_kind_t;
    localparam clcd_kind_t KIND_TICK   = 3'd0;
    localparam clcd_kind_t KIND_BYTE   = 3'd1;
    localparam clcd_kind_t KIND_NIBBLE = 3'd2;
    localparam clcd_kind_t KIND_CURSOR = 3'd3;
    localparam clcd_kind_t KIND_CGADDR = 3'd4;
    localparam clcd_kind_t KIND_INIT   = 3'd5;

    // status codes
    typedef logic [1:0] clcd_status_t;
    localparam clcd_status_t STAT_OK    = 2'd0;
    localparam clcd_status_t STAT_BUSY  = 2'd1;
    localparam clcd_status_t STAT_RANGE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] clcd_cfg_index_t;
    localparam clcd_cfg_index_t CFG_PULSE    = 2'd0;
    localparam clcd_cfg_index_t CFG_STANDARD = 2'd1;
    localparam clcd_cfg_index_t CFG_EXTENDED = 2'd2;
    localparam clcd_cfg_index_t CFG_POWERUP  = 2'd3;

    localparam int CFG_DATA_BITS = 20;
    typedef logic [CFG_DATA_BITS-1:0] clcd_cfg_data_t;

    localparam clcd_cfg_data_t PULSE_RESET    = 20'd5;
    localparam clcd_cfg_data_t STANDARD_RESET = 20'd100;
    localparam clcd_cfg_data_t EXTENDED_RESET = 20'd2000;
    localparam clcd_cfg_data_t POWERUP_RESET  = 20'd20000;

    typedef struct packed {
        clcd_cfg_data_t pulse_ticks;
        clcd_cfg_data_t standard_ticks;
        clcd_cfg_data_t extended_ticks;
        clcd_cfg_data_t powerup_ticks;
    } clcd_cfg_t;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWERUP,
        PH_ELOW1,
        PH_EHIGH,
        PH_ELOW2,
        PH_SETTLE,
        PH_EXT
    } clcd_phase_t;

    // init sequence
    localparam logic [3:0] INIT_FIRST = 4'd1;
    localparam logic [3:0] INIT_LAST  = 4'd11;

    // lcd command constants
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [1:0] CMD_CGRAM_TOP = 2'b01;
    localparam logic [7:0] CMD_LONG_MAX  = 8'h03;
    localparam logic [3:0] NIB_RESET     = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
    localparam logic [7:0] CMD_SHIFT     = 8'h10;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;

    // payload words
    typedef struct packed {
        clcd_kind_t  kind;
        logic        rs_select;
        logic [7:0]  value;
        logic [2:0]  row;
        logic [4:0]  column;
    } clcd_in_t;

    typedef struct packed {
        logic         enable_pin;
        logic         select_pin;
        logic [3:0]   data_pins;
        logic         busy_res;
        clcd_status_t status;
    } clcd_out_t;

endpackage

FILE: hdl/clcd_cfg_regs.sv
// clcd_cfg_regs: timing configuration registers with a plain write port
// depends on clcd_pkg

module clcd_cfg_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  clcd_pkg::clcd_cfg_index_t cfg_index,
    input  clcd_pkg::clcd_cfg_data_t cfg_wdata,
    output clcd_pkg::clcd_cfg_t      cfg
);
    import clcd_pkg::*;

    clcd_cfg_t cfg_reg;
    clcd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PULSE:    cfg_next.pulse_ticks    = cfg_wdata;
                CFG_STANDARD: cfg_next.standard_ticks = cfg_wdata;
                CFG_EXTENDED: cfg_next.extended_ticks = cfg_wdata;
                CFG_POWERUP:  cfg_next.powerup_ticks  = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ticks    <= PULSE_RESET;
            cfg_reg.standard_ticks <= STANDARD_RESET;
            cfg_reg.extended_ticks <= EXTENDED_RESET;
            cfg_reg.powerup_ticks  <= POWERUP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/clcd_engine.sv
// clcd_engine: lcd sequencer state and the one-tick step logic
// depends on clcd_pkg

module clcd_engine #(
    parameter int ROWS       = 4,
    parameter int COLUMNS    = 20,
    parameter int TIMER_BITS = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  clcd_pkg::clcd_in_t  item,
    input  clcd_pkg::clcd_cfg_t cfg,
    output clcd_pkg::clcd_out_t result
);
    import clcd_pkg::*;

    localparam logic [32:0] TICK_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef logic [TIMER_BITS-1:0] tick_t;

    typedef struct packed {
        clcd_phase_t phase;
        tick_t       cnt;
        logic [7:0]  pbyte;
        logic        psel;
        logic        half_due;
        logic        byte_mode;
        logic [3:0]  init_step;
        logic [5:0]  pins;      // bit 0 enable, bit 1 select, bits 5:2 data
    } eng_state_t;

    eng_state_t   state_reg;
    eng_state_t   st_start;
    eng_state_t   state_next;
    clcd_status_t status;
    tick_t        tk_pulse;
    tick_t        tk_standard;
    tick_t        tk_extended;
    tick_t        tk_powerup;
    logic         cursor_bad;
    logic [7:0]   cursor_addr;

    // zero means one, oversize saturates to the counter maximum
    function automatic tick_t load_ticks(input clcd_cfg_data_t t);
        logic [32:0] w;
        w = {13'd0, t};
        if (t == '0) begin
            return tick_t'(1);
        end else if (w > TICK_MAX) begin
            return '1;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic eng_state_t enter(input eng_state_t s, input clcd_phase_t p,
                                         input tick_t ticks);
        eng_state_t r;
        r = s;
        r.phase = p;
        r.cnt = ticks;
        r.pins = {s.pins[5:1], (p == PH_EHIGH)};
        return r;
    endfunction

    function automatic eng_state_t present(input eng_state_t s, input logic [3:0] nib,
                                           input logic sel, input tick_t pulse);
        eng_state_t r;
        r = s;
        r.pins = {nib, sel, 1'b0};
        return enter(r, PH_ELOW1, pulse);
    endfunction

    function automatic eng_state_t start_nibble(input eng_state_t s, input logic [3:0] nib,
                                                input logic sel, input tick_t pulse);
        eng_state_t r;
        r = s;
        r.byte_mode = 1'b0;
        r.half_due = 1'b0;
        r.pbyte = {4'd0, nib};
        r.psel = sel;
        return present(r, nib, sel, pulse);
    endfunction

    function automatic eng_state_t start_byte(input eng_state_t s, input logic [7:0] b,
                                              input logic sel, input tick_t pulse);
        eng_state_t r;
        r = s;
        r.byte_mode = 1'b1;
        r.half_due = 1'b1;
        r.pbyte = b;
        r.psel = sel;
        return present(r, b[7:4], sel, pulse);
    endfunction

    function automatic eng_state_t start_init_item(input eng_state_t s, input tick_t pulse,
                                                   input tick_t pwr);
        eng_state_t r;
        case (s.init_step)
            4'd1, 4'd3, 4'd5: r = enter(s, PH_POWERUP, pwr);
            4'd2, 4'd4, 4'd6: r = start_nibble(s, NIB_RESET, 1'b0, pulse);
            4'd7:             r = start_nibble(s, NIB_4BIT, 1'b0, pulse);
            4'd8:             r = start_byte(s, CMD_FUNC_SET, 1'b0, pulse);
            4'd9:             r = start_byte(s, CMD_DISP_ON, 1'b0, pulse);
            4'd10:            r = start_byte(s, CMD_SHIFT, 1'b0, pulse);
            default:          r = start_byte(s, CMD_CLEAR, 1'b0, pulse);
        endcase
        return r;
    endfunction

    function automatic eng_state_t finish_item(input eng_state_t s, input tick_t pulse,
                                               input tick_t pwr);
        eng_state_t r;
        r = s;
        if (s.init_step != 4'd0 && s.init_step < INIT_LAST) begin
            r.init_step = s.init_step + 4'd1;
            r = start_init_item(r, pulse, pwr);
        end else begin
            r.init_step = 4'd0;
            r.phase = PH_IDLE;
            r.cnt = '0;
            r.pins = {s.pins[5:1], 1'b0};
        end
        return r;
    endfunction

    assign tk_pulse    = load_ticks(cfg.pulse_ticks);
    assign tk_standard = load_ticks(cfg.standard_ticks);
    assign tk_extended = load_ticks(cfg.extended_ticks);
    assign tk_powerup  = load_ticks(cfg.powerup_ticks);

    // cursor address: row offsets 0, 0x40, COLUMNS, 0x40 + COLUMNS
    assign cursor_bad  = (item.row >= 3'(ROWS)) || ({1'b0, item.column} >= 6'(COLUMNS));
    assign cursor_addr = ((item.row[0] ? ROW1_OFFSET : 8'd0)
                        + (item.row[1] ? 8'(COLUMNS) : 8'd0)
                        + {3'd0, item.column}) | CMD_DDRAM;

    // command start
    always_comb begin
        st_start = state_reg;
        status = STAT_OK;
        if (item.kind inside {KIND_BYTE, KIND_NIBBLE, KIND_CURSOR, KIND_CGADDR, KIND_INIT})
        begin
            if (state_reg.phase != PH_IDLE) begin
                status = STAT_BUSY;
            end else begin
                st_start.init_step = 4'd0;
                unique case (item.kind)
                    KIND_BYTE: begin
                        st_start = start_byte(st_start, item.value, item.rs_select, tk_pulse);
                    end
                    KIND_NIBBLE: begin
                        st_start = start_nibble(st_start, item.value[3:0], item.rs_select,
                                                tk_pulse);
                    end
                    KIND_CURSOR: begin
                        if (cursor_bad) begin
                            status = STAT_RANGE;
                        end else begin
                            st_start = start_byte(st_start, cursor_addr, 1'b0, tk_pulse);
                        end
                    end
                    KIND_CGADDR: begin
                        st_start = start_byte(st_start, {CMD_CGRAM_TOP, item.value[5:0]},
                                              1'b0, tk_pulse);
                    end
                    KIND_INIT: begin
                        st_start.init_step = INIT_FIRST;
                        st_start = start_init_item(st_start, tk_pulse, tk_powerup);
                    end
                    default: st_start = state_reg;
                endcase
            end
        end
    end

    // tick: count down and move to the next phase at zero
    always_comb begin
        state_next = st_start;
        if (st_start.phase != PH_IDLE) begin
            if (st_start.cnt != '0) begin
                state_next.cnt = st_start.cnt - tick_t'(1);
            end
            if (state_next.cnt == '0) begin
                unique case (st_start.phase)
                    PH_POWERUP: state_next = finish_item(state_next, tk_pulse, tk_powerup);
                    PH_ELOW1:   state_next = enter(state_next, PH_EHIGH, tk_pulse);
                    PH_EHIGH:   state_next = enter(state_next, PH_ELOW2, tk_pulse);
                    PH_ELOW2:   state_next = enter(state_next, PH_SETTLE, tk_standard);
                    PH_SETTLE: begin
                        if (st_start.byte_mode && st_start.half_due) begin
                            state_next.half_due = 1'b0;
                            state_next = present(state_next, st_start.pbyte[3:0],
                                                 st_start.psel, tk_pulse);
                        end else if (st_start.byte_mode && !st_start.psel
                                     && st_start.pbyte <= CMD_LONG_MAX) begin
                            state_next = enter(state_next, PH_EXT, tk_extended);
                        end else begin
                            state_next = finish_item(state_next, tk_pulse, tk_powerup);
                        end
                    end
                    PH_EXT:     state_next = finish_item(state_next, tk_pulse, tk_powerup);
                    default: begin
                        state_next.phase = PH_IDLE;
                        state_next.cnt = '0;
                    end
                endcase
            end
        end
    end

    // result word: pins as driven this tick, busy after the tick
    always_comb begin
        result.enable_pin = st_start.pins[0];
        result.select_pin = st_start.pins[1];
        result.data_pins  = st_start.pins[5:2];
        result.busy_res   = (state_next.phase != PH_IDLE);
        result.status     = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= PH_IDLE;
            state_reg.cnt       <= '0;
            state_reg.pbyte     <= '0;
            state_reg.psel      <= 1'b0;
            state_reg.half_due  <= 1'b0;
            state_reg.byte_mode <= 1'b0;
            state_reg.init_step <= '0;
            state_reg.pins      <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/char_lcd_nibble_interface.sv
// char_lcd_nibble_interface: hd44780-style lcd driver on a 4-bit bus, one word per tick
// path: a word accepted into the input register takes its tick in the engine, then moves to the result register
// throughput: one word per cycle; the input and result registers each take a new word
//   whenever the stage behind them moves, so stalls on m_ready only back up the input
// reset: aresetn synchronous, active low; sequencer idle, pins low, timing registers
//   back to their defaults (5, 100, 2000, 20000 ticks)
// depends on clcd_pkg, clcd_cfg_regs, clcd_engine

module char_lcd_nibble_interface #(
    parameter int ROWS       = 4,
    parameter int COLUMNS    = 20,
    parameter int TIMER_BITS = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // command words
    input  logic                      s_valid,
    output logic                      s_ready,
    input  clcd_pkg::clcd_in_t        s_data,
    // pin level words, one per tick
    output logic                      m_valid,
    input  logic                      m_ready,
    output clcd_pkg::clcd_out_t       m_data,
    // timing configuration
    input  logic                      cfg_wr_en,
    input  clcd_pkg::clcd_cfg_index_t cfg_index,
    input  clcd_pkg::clcd_cfg_data_t  cfg_wdata
);
    import clcd_pkg::*;

    clcd_cfg_t cfg;
    clcd_out_t step_result;
    logic      step_en;

    // input register
    logic      in_valid_reg;
    logic      in_valid_next;
    clcd_in_t  in_data_reg;
    clcd_in_t  in_data_next;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    clcd_out_t out_data_reg;
    clcd_out_t out_data_next;

    // timing registers
    clcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // a held word takes its tick when the result register is free or draining
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    // sequencer: state advances exactly once per word that moves to the result register
    clcd_engine #(
        .ROWS       (ROWS),
        .COLUMNS    (COLUMNS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: tb/clcd_tb_pkg.sv
`timescale 1ns / 1ps
// clcd_tb_pkg: pin-level scoreboard for the 4-bit character lcd controller
// depends on clcd_pkg; used by the testbench top module

package clcd_tb_pkg;

    import clcd_pkg::*;

    localparam int ROWS       = 4;
    localparam int COLUMNS    = 20;
    localparam int TIMER_BITS = 20;

    class lcd_pin_scoreboard;

        clcd_cfg_t             timing;
        clcd_phase_t           phase;
        logic [TIMER_BITS-1:0] count;
        logic [7:0]            pend_byte;
        logic                  pend_sel;
        logic                  low_half_due;
        logic                  byte_mode;
        logic [3:0]            init_step;
        logic [5:0]            pins;     // bit 0 enable, bit 1 select, bits 5:2 data
        clcd_out_t             expected_pins[$];
        int                    errors;

        function new();
            timing.pulse_ticks    = PULSE_RESET;
            timing.standard_ticks = STANDARD_RESET;
            timing.extended_ticks = EXTENDED_RESET;
            timing.powerup_ticks  = POWERUP_RESET;
            phase        = PH_IDLE;
            count        = '0;
            pend_byte    = '0;
            pend_sel     = 1'b0;
            low_half_due = 1'b0;
            byte_mode    = 1'b0;
            init_step    = '0;
            pins         = '0;
            errors       = 0;
        endfunction

        function void write_reg(clcd_cfg_index_t idx, clcd_cfg_data_t val);
            case (idx)
                CFG_PULSE:    timing.pulse_ticks    = val;
                CFG_STANDARD: timing.standard_ticks = val;
                CFG_EXTENDED: timing.extended_ticks = val;
                default:      timing.powerup_ticks  = val;
            endcase
        endfunction

        function bit engine_busy();
            return phase != PH_IDLE;
        endfunction

        function int pending_words();
            return expected_pins.size();
        endfunction

        // zero counts as one tick, anything above the timer saturates
        function logic [TIMER_BITS-1:0] load_count(clcd_cfg_data_t t);
            longint unsigned top;
            top = (longint'(1) << TIMER_BITS) - 1;
            if (t == 0) begin
                return TIMER_BITS'(1);
            end
            return (t > top) ? TIMER_BITS'(top) : TIMER_BITS'(t);
        endfunction

        function void enter(clcd_phase_t p, clcd_cfg_data_t ticks);
            phase   = p;
            count   = load_count(ticks);
            pins[0] = (p == PH_EHIGH);
        endfunction

        function void present_nibble(logic [3:0] nib, logic sel);
            pins = {nib, sel, 1'b0};
            enter(PH_ELOW1, timing.pulse_ticks);
        endfunction

        function void start_nibble(logic [3:0] nib, logic sel);
            byte_mode    = 1'b0;
            low_half_due = 1'b0;
            pend_byte    = {4'h0, nib};
            pend_sel     = sel;
            present_nibble(nib, sel);
        endfunction

        function void start_byte(logic [7:0] b, logic sel);
            byte_mode    = 1'b1;
            low_half_due = 1'b1;
            pend_byte    = b;
            pend_sel     = sel;
            present_nibble(b[7:4], sel);
        endfunction

        function void start_init_item(logic [3:0] s);
            case (s)
                4'd1, 4'd3, 4'd5: enter(PH_POWERUP, timing.powerup_ticks);
                4'd2, 4'd4, 4'd6: start_nibble(NIB_RESET, 1'b0);
                4'd7:             start_nibble(NIB_4BIT, 1'b0);
                4'd8:             start_byte(CMD_FUNC_SET, 1'b0);
                4'd9:             start_byte(CMD_DISP_ON, 1'b0);
                4'd10:            start_byte(CMD_SHIFT, 1'b0);
                default:          start_byte(CMD_CLEAR, 1'b0);
            endcase
        endfunction

        function void finish_item();
            if (init_step != 0 && init_step < INIT_LAST) begin
                init_step++;
                start_init_item(init_step);
            end else begin
                init_step = '0;
                phase     = PH_IDLE;
                count     = '0;
                pins[0]   = 1'b0;
            end
        endfunction

        function void advance();
            case (phase)
                PH_POWERUP: finish_item();
                PH_ELOW1:   enter(PH_EHIGH, timing.pulse_ticks);
                PH_EHIGH:   enter(PH_ELOW2, timing.pulse_ticks);
                PH_ELOW2:   enter(PH_SETTLE, timing.standard_ticks);
                PH_SETTLE: begin
                    if (byte_mode && low_half_due) begin
                        low_half_due = 1'b0;
                        present_nibble(pend_byte[3:0], pend_sel);
                    end else if (byte_mode && !pend_sel && pend_byte <= CMD_LONG_MAX) begin
                        enter(PH_EXT, timing.extended_ticks);
                    end else begin
                        finish_item();
                    end
                end
                PH_EXT:     finish_item();
                default: begin
                    phase = PH_IDLE;
                    count = '0;
                end
            endcase
        endfunction

        // one accepted command word gives exactly one pin word
        function void note_command(clcd_in_t w);
            clcd_status_t st;
            logic [7:0]   offset;
            logic [5:0]   shown;
            clcd_out_t    e;
            st = STAT_OK;
            case (w.kind) inside
                KIND_BYTE, KIND_NIBBLE, KIND_CURSOR, KIND_CGADDR, KIND_INIT: begin
                    if (phase != PH_IDLE) begin
                        st = STAT_BUSY;
                    end else begin
                        init_step = '0;
                        case (w.kind)
                            KIND_BYTE:   start_byte(w.value, w.rs_select);
                            KIND_NIBBLE: start_nibble(w.value[3:0], w.rs_select);
                            KIND_CURSOR: begin
                                if (w.row >= ROWS || w.column >= COLUMNS) begin
                                    st = STAT_RANGE;
                                end else begin
                                    offset = (w.row[0] ? ROW1_OFFSET : 8'h00)
                                           + (w.row[1] ? 8'(COLUMNS) : 8'h00);
                                    start_byte((offset + 8'(w.column)) | CMD_DDRAM, 1'b0);
                                end
                            end
                            KIND_CGADDR: start_byte({CMD_CGRAM_TOP, w.value[5:0]}, 1'b0);
                            default: begin
                                init_step = INIT_FIRST;
                                start_init_item(INIT_FIRST);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            shown = pins;
            if (phase != PH_IDLE) begin
                if (count != 0) begin
                    count--;
                end
                if (count == 0) begin
                    advance();
                end
            end
            e.enable_pin = shown[0];
            e.select_pin = shown[1];
            e.data_pins  = shown[5:2];
            e.busy_res   = (phase != PH_IDLE);
            e.status     = st;
            expected_pins.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 50) begin
                $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
            end
            errors++;
        endtask

        task check_pins(clcd_out_t got);
            clcd_out_t want;
            if (expected_pins.size() == 0) begin
                report_mismatch("word with nothing expected", got, '0);
                return;
            end
            want = expected_pins.pop_front();
            if (got.enable_pin !== want.enable_pin) begin
                report_mismatch("enable_pin", got.enable_pin, want.enable_pin);
            end
            if (got.select_pin !== want.select_pin) begin
                report_mismatch("select_pin", got.select_pin, want.select_pin);
            end
            if (got.data_pins !== want.data_pins) begin
                report_mismatch("data_pins", got.data_pins, want.data_pins);
            end
            if (got.busy_res !== want.busy_res) begin
                report_mismatch("busy_res", got.busy_res, want.busy_res);
            end
            if (got.status !== want.status) begin
                report_mismatch("status", got.status, want.status);
            end
        endtask

    endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: drives command words into the 4-bit lcd controller and checks every pin word
// depends on clcd_pkg, clcd_tb_pkg and the char_lcd_nibble_interface rtl

module testbench;

    import clcd_pkg::*;
    import clcd_tb_pkg::*;

    // the two kinds the block treats as a plain tick
    localparam clcd_kind_t KIND_SPARE_A = 3'd6;
    localparam clcd_kind_t KIND_SPARE_B = 3'd7;

    localparam int PHASE_WORDS  = 140;   // useful words per random phase
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 4;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    clcd_in_t            s_data;
    logic                m_valid;
    logic                m_ready;
    clcd_out_t           m_data;
    logic                cfg_wr_en;
    clcd_cfg_index_t     cfg_index;
    clcd_cfg_data_t      cfg_wdata;

    lcd_pin_scoreboard   pin_model;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  hold_req;
    int                  quiet_cycles;

    char_lcd_nibble_interface #(
        .ROWS       (ROWS),
        .COLUMNS    (COLUMNS),
        .TIMER_BITS (TIMER_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random back-pressure at each falling edge, plus one long hold-off
    // on request while the sender keeps pushing, so the pipeline fills and s_ready drops
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: everything sampled at the rising edge, before the dut updates;
    // the command is predicted first so a same-edge pin word still finds the fifo in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pin_model.note_command(s_data);
            end
            if (m_valid && m_ready) begin
                pin_model.check_pins(m_data);
            end
            // watchdog: a run where nothing moves for too long is hung
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic clcd_in_t make_word(clcd_kind_t k, logic rs, logic [7:0] v,
                                           logic [2:0] r, logic [4:0] c);
        clcd_in_t w;
        w.kind      = k;
        w.rs_select = rs;
        w.value     = v;
        w.row       = r;
        w.column    = c;
        return w;
    endfunction

    // random command word; while the sequencer runs it is mostly ticks, with a few
    // commands that must be refused, and when idle it is mostly real commands
    function automatic clcd_in_t random_word(bit busy);
        clcd_in_t w;
        int       pick;
        w = make_word(KIND_TICK, $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(31));
        pick = $urandom_range(99);
        if (busy) begin
            if (pick < 12) begin
                w.kind = $urandom_range(KIND_BYTE, KIND_INIT);
            end else if (pick < 18) begin
                w.kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
            end
        end else if (pick < 85) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                w.kind = KIND_BYTE;
                // clear/home style commands, values 0 to 4; all but 4 trigger the long wait
                if ($urandom_range(3) == 0) begin
                    w.rs_select = 1'b0;
                    w.value     = $urandom_range(4);
                end
            end else if (pick < 45) begin
                w.kind = KIND_NIBBLE;
            end else if (pick < 70) begin
                w.kind = KIND_CURSOR;
                // mostly legal positions, the rest anywhere in the field range
                if ($urandom_range(3) != 0) begin
                    w.row    = $urandom_range(ROWS - 1);
                    w.column = $urandom_range(COLUMNS - 1);
                end
            end else if (pick < 92) begin
                w.kind = KIND_CGADDR;
            end else begin
                w.kind = KIND_INIT;
            end
        end else if (pick < 92) begin
            w.kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
        end
        return w;
    endfunction

    // offer one word, with random idle cycles ahead of it; entered and left at a falling edge
    task automatic send_word(clcd_in_t w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // feed plain ticks until the predicted sequencer is back to idle
    task automatic tick_until_idle();
        while (pin_model.engine_busy()) begin
            send_word(make_word(KIND_TICK, $urandom_range(1), $urandom_range(255),
                                $urandom_range(7), $urandom_range(31)));
        end
    endtask

    task automatic run_command(clcd_in_t w);
        send_word(w);
        tick_until_idle();
    endtask

    // wait for every pin word to come back, then wait out DRAIN_CYCLES for strays
    task automatic drain();
        s_valid <= 1'b0;
        while (pin_model.pending_words() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // all four timing registers, one per cycle, only while nothing is in flight
    task automatic load_timing(clcd_cfg_data_t pulse, clcd_cfg_data_t standard,
                               clcd_cfg_data_t extended, clcd_cfg_data_t powerup);
        clcd_cfg_index_t idx [4];
        clcd_cfg_data_t  val [4];
        idx = '{CFG_PULSE, CFG_STANDARD, CFG_EXTENDED, CFG_POWERUP};
        val = '{pulse, standard, extended, powerup};
        foreach (idx[i]) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            pin_model.write_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        clcd_in_t w;
        bit       busy;
        int       useful;
        pin_model      = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_PULSE;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset timing: one data byte at the default pulse and settle lengths
        run_command(make_word(KIND_BYTE, 1'b1, 8'h48, 3'd0, 5'd0));
        drain();

        // directed: shortest timing so each sequence is only a handful of ticks
        load_timing(1, 1, 1, 1);
        run_command(make_word(KIND_BYTE, 1'b0, 8'h00, 3'd0, 5'd0));   // long wait, lowest
        run_command(make_word(KIND_BYTE, 1'b0, 8'h03, 3'd0, 5'd0));   // long wait, highest
        run_command(make_word(KIND_BYTE, 1'b0, 8'h04, 3'd0, 5'd0));   // just past it
        run_command(make_word(KIND_BYTE, 1'b1, 8'h00, 3'd0, 5'd0));   // data zero, no long wait
        run_command(make_word(KIND_BYTE, 1'b1, 8'hFF, 3'd7, 5'd31));
        run_command(make_word(KIND_NIBBLE, 1'b1, 8'hFF, 3'd0, 5'd0)); // upper bits dropped
        run_command(make_word(KIND_NIBBLE, 1'b0, 8'h00, 3'd0, 5'd0));
        run_command(make_word(KIND_CURSOR, 1'b1, 8'hFF, 3'd0, 5'd0));
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'd1, 5'(COLUMNS - 1)));
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'd2, 5'd0));
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'(ROWS - 1), 5'(COLUMNS - 1)));
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'(ROWS), 5'd0));      // row too big
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'd0, 5'(COLUMNS)));   // column too big
        run_command(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'd7, 5'd31));
        run_command(make_word(KIND_CGADDR, 1'b1, 8'h00, 3'd0, 5'd0));
        run_command(make_word(KIND_CGADDR, 1'b0, 8'hFF, 3'd0, 5'd0));
        run_command(make_word(KIND_INIT, 1'b1, 8'hA5, 3'd0, 5'd0));
        run_command(make_word(KIND_SPARE_A, 1'b1, 8'h5A, 3'd7, 5'd31));
        run_command(make_word(KIND_SPARE_B, 1'b0, 8'h00, 3'd0, 5'd0));
        // refusal while busy wins over a bad cursor position
        send_word(make_word(KIND_BYTE, 1'b1, 8'h81, 3'd0, 5'd0));
        send_word(make_word(KIND_CURSOR, 1'b0, 8'h00, 3'd7, 5'd31));
        send_word(make_word(KIND_INIT, 1'b0, 8'h00, 3'd0, 5'd0));
        tick_until_idle();
        drain();

        // random phases: new timing each time, idling pattern rotating through the four modes
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_timing(1, 1, 1, 1);
                1: load_timing(0, 0, 0, 0);            // zero behaves as one tick
                2: load_timing(2, 3, 5, 4);
                3: load_timing(1, 2, 1, 3);
                4: load_timing(3, 1, 2, 1);
                5: load_timing($urandom_range(1, 4), $urandom_range(1, 4),
                               $urandom_range(1, 4), $urandom_range(1, 4));
                6: load_timing($urandom_range(0, 5), $urandom_range(0, 5),
                               $urandom_range(0, 5), $urandom_range(0, 5));
                default: load_timing(1, 1, 7, 2);
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            if (p == 0) begin
                hold_req = 1'b1;
            end
            useful = 0;
            while (useful < PHASE_WORDS) begin
                busy = pin_model.engine_busy();
                w    = random_word(busy);
                // commands refused while busy are not counted as progress
                if (!(busy && w.kind inside {[KIND_BYTE:KIND_INIT]})) begin
                    useful++;
                end
                send_word(w);
            end
            drain();
        end

        // largest timing values: sequences do not finish within this phase, so it stays the last phase
        load_timing('1, '1, '1, '1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (60) begin
            send_word(random_word(pin_model.engine_busy()));
        end
        drain();

        if (pin_model.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
